FILE: rtl/core/fpba_pkg.sv
// Shared constants, codes and types for the fit-policy block allocator.
package fpba_pkg;

  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;
  localparam int TDATA_W  = 24;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

endpackage

FILE: rtl/core/fpba_table.sv
// Free-size table: one write port, one registered read port.
module fpba_table #(
  parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF,
  localparam int IDX_W    = $clog2(BLOCKS)
) (
  input  logic                  clk,
  input  fpba_pkg::tbl_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [SIZE_BITS-1:0]  wdata,
  input  logic [IDX_W-1:0]      raddr,
  output logic [SIZE_BITS-1:0]  rdata
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] mem [BLOCKS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/fpba_ctrl.sv
// Sequencer: writes loads into the table; requests scan it, pick by policy, write back, emit.
module fpba_ctrl #(
  parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF,
  localparam int IDX_W    = $clog2(BLOCKS),
  localparam int CNT_W    = $clog2(BLOCKS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [fpba_pkg::INDEX_W-1:0]    in_index,
  input  logic [fpba_pkg::AMOUNT_W-1:0]   in_amount,
  input  logic [fpba_pkg::POLICY_W-1:0]   fit_policy,
  input  logic [fpba_pkg::COUNT_W-1:0]    blocks_in_use,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_allocated,
  output logic [fpba_pkg::INDEX_W-1:0]    out_block,
  output logic [fpba_pkg::AMOUNT_W-1:0]   out_remaining,
  output fpba_pkg::tbl_ctrl_t             tbl,
  output logic [IDX_W-1:0]                waddr,
  output logic [SIZE_BITS-1:0]            wdata,
  output logic [IDX_W-1:0]                raddr,
  input  logic [SIZE_BITS-1:0]            rdata
);
  import fpba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t               state;
  logic [SIZE_BITS-1:0] amount_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     ridx;
  logic [IDX_W-1:0]     eidx;
  logic                 rvalid;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] pick_size;
  logic [SIZE_BITS-1:0] diff;
  logic                 accept;
  logic                 emit;
  logic                 fits;
  logic                 take;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == ST_FINISH) && (!out_valid || out_ready);
  assign diff     = pick_size - amount_q;

  // saturate the searched count to the table depth
  always_comb begin
    if (32'(blocks_in_use) > BLOCKS) begin
      count_next = CNT_W'(BLOCKS);
    end else begin
      count_next = CNT_W'(blocks_in_use);
    end
  end

  always_comb begin
    fits = (rdata >= amount_q);
    take = 1'b0;
    if (rvalid && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_policy == POLICY_BEST) begin
        take = (rdata < pick_size);
      end else if (fit_policy == POLICY_WORST) begin
        take = (rdata > pick_size);
      end
    end
  end

  always_comb begin
    tbl.rd_en = (state == ST_SCAN) && (ridx < count_q);
    raddr     = ridx[IDX_W-1:0];
    tbl.wr_en = 1'b0;
    waddr     = pick;
    wdata     = diff;
    if (accept && (in_kind == KIND_LOAD) && (32'(in_index) < BLOCKS)) begin
      tbl.wr_en = 1'b1;
      waddr     = IDX_W'(in_index);
      wdata     = SIZE_BITS'(in_amount);
    end else if (emit && found) begin
      tbl.wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rvalid    <= 1'b0;
      found     <= 1'b0;
      ridx      <= '0;
      count_q   <= '0;
    end else begin
      rvalid <= tbl.rd_en;
      eidx   <= raddr;
      if (emit) begin
        out_valid     <= 1'b1;
        out_allocated <= found;
        out_block     <= found ? INDEX_W'(pick) : '0;
        out_remaining <= found ? AMOUNT_W'(diff) : '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (in_kind == KIND_REQUEST)) begin
            amount_q <= SIZE_BITS'(in_amount);
            count_q  <= count_next;
            ridx     <= '0;
            found    <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tbl.rd_en) begin
            ridx <= ridx + 1'b1;
          end
          if (take) begin
            found     <= 1'b1;
            pick      <= eidx;
            pick_size <= rdata;
          end
          if (!tbl.rd_en && !rvalid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/fit_policy_block_allocator.sv
// Fit-policy block allocator top level: stream ports, APB registers, sequencer and table.
//
// A load item writes one entry of the free-size table in the cycle it is
// accepted and gives no result. A request item scans entries 0 to
// blocks_in_use-1 (saturated to BLOCKS), one table read per cycle through the
// single read port, then writes the reduced size back and loads the output
// register. No new item is accepted until the result is loaded, and a result
// still waiting in the output register delays that. First fit (and the unused
// policy code 3) takes the lowest fitting index, best fit the smallest
// fitting entry, worst fit the largest; ties go to the lower index.
// A request that finds nothing returns allocated = 0 with zero fields and leaves
// the table unchanged. Table entries are undefined until loaded. Registers:
// fit_policy at 0x0, blocks_in_use at 0x4; write them only while idle.
module fit_policy_block_allocator #(
  parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fpba_pkg::TDATA_W-1:0]  s_tdata,  // block_index[3:0], amount[19:4]
  input  logic                          s_tuser,  // kind[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fpba_pkg::TDATA_W-1:0]  m_tdata,  // chosen_block[3:0], remaining[19:4]
  output logic                          m_tuser,  // allocated[0]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fpba_pkg::*;

  localparam int IDX_W = $clog2(BLOCKS);

  logic [POLICY_W-1:0]  fit_policy;
  logic [COUNT_W-1:0]   blocks_in_use;
  logic                 cfg_write;
  tbl_ctrl_t            tbl;
  logic [IDX_W-1:0]     waddr;
  logic [SIZE_BITS-1:0] wdata;
  logic [IDX_W-1:0]     raddr;
  logic [SIZE_BITS-1:0] rdata;
  logic [INDEX_W-1:0]   out_block;
  logic [AMOUNT_W-1:0]  out_remaining;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BLOCKS_IN_USE) ? 32'(blocks_in_use) : 32'(fit_policy);

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= POLICY_FIRST;
      blocks_in_use <= COUNT_W'(16);
    end else if (cfg_write) begin
      if (paddr[2] == REG_FIT_POLICY) begin
        fit_policy <= pwdata[POLICY_W-1:0];
      end else begin
        blocks_in_use <= pwdata[COUNT_W-1:0];
      end
    end
  end

  fpba_ctrl #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_kind       (s_tuser),
    .in_index      (s_tdata[3:0]),
    .in_amount     (s_tdata[19:4]),
    .fit_policy    (fit_policy),
    .blocks_in_use (blocks_in_use),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_allocated (m_tuser),
    .out_block     (out_block),
    .out_remaining (out_remaining),
    .tbl           (tbl),
    .waddr         (waddr),
    .wdata         (wdata),
    .raddr         (raddr),
    .rdata         (rdata)
  );

  fpba_table #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_table (
    .clk   (clk),
    .ctrl  (tbl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign m_tdata = {4'b0000, out_remaining, out_block};

endmodule

FILE: dv/fpba_grant_monitor.sv
// Watches the allocator's channels, predicts each grant and compares it with the block.
module fpba_grant_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [fpba_pkg::TDATA_W-1:0]  s_tdata,  // block_index[3:0], amount[19:4]
  input  logic                          s_tuser,  // kind[0]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [fpba_pkg::TDATA_W-1:0]  m_tdata,  // chosen_block[3:0], remaining[19:4]
  input  logic                          m_tuser,  // allocated[0]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;

  typedef struct packed {
    logic                allocated;
    logic [INDEX_W-1:0]  slot;
    logic [AMOUNT_W-1:0] remaining;
  } grant_t;

  logic [AMOUNT_W-1:0] free_size [BLOCKS_DEF];
  logic [POLICY_W-1:0] fit_mode;
  logic [COUNT_W-1:0]  search_len;
  grant_t              pending_grants [$];
  grant_t              seen_grant;
  grant_t              due_grant;

  // Pick a block for one request and take the request out of it.
  function automatic grant_t allocate(input logic [AMOUNT_W-1:0] want);
    int     lim;
    int     pick;
    bit     found;
    grant_t g;
    lim = (search_len > BLOCKS_DEF) ? BLOCKS_DEF : int'(search_len);
    pick = 0;
    found = 1'b0;
    g = '0;
    for (int j = 0; j < lim; j++) begin
      if (free_size[j] < want) continue;
      if (!found) begin
        found = 1'b1;
        pick = j;
        // first fit and the spare code stop at the lowest fitting index
        if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) break;
      end else if (fit_mode == POLICY_BEST && free_size[j] < free_size[pick]) begin
        pick = j;
      end else if (fit_mode == POLICY_WORST && free_size[j] > free_size[pick]) begin
        pick = j;
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - want;
      g.allocated = 1'b1;
      g.slot = INDEX_W'(pick);
      g.remaining = free_size[pick];
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fit_mode = POLICY_FIRST;
      search_len = COUNT_W'(BLOCKS_DEF);
      foreach (free_size[i]) free_size[i] = '0;
      pending_grants.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_grant.allocated = m_tuser;
        seen_grant.slot = m_tdata[INDEX_W-1:0];
        seen_grant.remaining = m_tdata[INDEX_W +: AMOUNT_W];
        if (pending_grants.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result allocated=%0d block=%0d remaining=%0d",
                   $time, seen_grant.allocated, seen_grant.slot, seen_grant.remaining);
        end else begin
          due_grant = pending_grants.pop_front();
          if (seen_grant.allocated !== due_grant.allocated ||
              seen_grant.slot !== due_grant.slot ||
              seen_grant.remaining !== due_grant.remaining) begin
            mismatches++;
            $display("%0t: expected allocated=%0d block=%0d remaining=%0d, got %0d/%0d/%0d",
                     $time, due_grant.allocated, due_grant.slot, due_grant.remaining,
                     seen_grant.allocated, seen_grant.slot, seen_grant.remaining);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_LOAD) begin
          free_size[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: AMOUNT_W];
        end else begin
          pending_grants.push_back(allocate(s_tdata[INDEX_W +: AMOUNT_W]));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FIT_POLICY) begin
          fit_mode = pwdata[POLICY_W-1:0];
        end else begin
          search_len = pwdata[COUNT_W-1:0];
        end
      end
      outstanding = pending_grants.size();
    end
  end

endmodule

FILE: dv/fit_policy_block_allocator_test.sv
// Testbench top for the fit-policy block allocator: clock, reset, stimulus and verdict.
module fit_policy_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 25;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 75;

  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

  localparam logic [AMOUNT_W-1:0] SEED_SIZE [BLOCKS_DEF] = '{
    16'd0, 16'd500, 16'd300, 16'd300, 16'd900, 16'd100, 16'd700, 16'd300,
    16'd2000, 16'd40000, 16'd40000, 16'd100, 16'd1200, 16'd60000, 16'd800, 16'd65535
  };
  localparam logic [POLICY_W-1:0] PHASE_POLICY [PHASES] = '{
    POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE,
    POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_BEST
  };
  localparam logic [COUNT_W-1:0] PHASE_SPAN [PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd8, 5'd17, 5'd0, 5'd16, 5'd16
  };

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;   // block_index[3:0], amount[19:4]
  logic                s_tuser;   // kind[0]
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;   // chosen_block[3:0], remaining[19:4]
  logic                m_tuser;   // allocated[0]
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bit                  steady;
  bit                  hold_req;
  int                  mismatches;
  int                  outstanding;

  fit_policy_block_allocator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fpba_grant_monitor i_monitor (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one item (load or request) to the block, with random gaps ahead of it unless steady.
  task automatic push_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(TDATA_W - INDEX_W - AMOUNT_W){1'b0}}, amt, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, wait for every grant, then wait out the SETTLE delay.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("fit_policy_block_allocator_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic                kind;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;
    logic [COUNT_W-1:0]  span;
    int                  r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = KIND_LOAD;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole table first so no request ever reads an unloaded entry
    for (int i = 0; i < BLOCKS_DEF; i++) push_item(KIND_LOAD, INDEX_W'(i), SEED_SIZE[i]);
    push_item(KIND_REQUEST, 4'd0, 16'd0);
    push_item(KIND_REQUEST, 4'd0, 16'hFFFF);
    push_item(KIND_REQUEST, 4'd15, 16'hFFFF);   // nothing fits any more
    drain();
    reg_write(REG_FIT_POLICY, 32'(POLICY_BEST));
    push_item(KIND_REQUEST, 4'd0, 16'd300);      // three equal entries, lowest wins
    push_item(KIND_REQUEST, 4'd0, 16'd100);
    drain();
    reg_write(REG_FIT_POLICY, 32'(POLICY_WORST));
    push_item(KIND_REQUEST, 4'd0, 16'd1);
    push_item(KIND_REQUEST, 4'd0, 16'd20000);
    drain();
    reg_write(REG_BLOCKS_IN_USE, 32'd0);         // empty search
    push_item(KIND_REQUEST, 4'd0, 16'd0);
    drain();
    reg_write(REG_FIT_POLICY, 32'(POLICY_SPARE));
    reg_write(REG_BLOCKS_IN_USE, 32'd31);        // saturates to the table size
    push_item(KIND_REQUEST, 4'd0, 16'd50);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      span = (p == PHASES - 1) ? COUNT_W'($urandom_range(2, 15)) : PHASE_SPAN[p];
      reg_write(REG_FIT_POLICY, 32'(PHASE_POLICY[p]));
      reg_write(REG_BLOCKS_IN_USE, 32'(span));
      steady = (p == 2);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        kind = (r < 40) ? KIND_LOAD : KIND_REQUEST;
        idx = INDEX_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (kind == KIND_LOAD) begin
          // repeated sizes give ties, full range covers every bit
          if (r < 25) amt = AMOUNT_W'(256 << $urandom_range(0, 3));
          else if (r < 75) amt = AMOUNT_W'($urandom_range(0, 8191));
          else amt = AMOUNT_W'($urandom);
        end else begin
          if (r < 10) amt = '0;
          else if (r < 15) amt = '1;
          else if (r < 65) amt = AMOUNT_W'($urandom_range(0, 2047));
          else amt = AMOUNT_W'($urandom_range(0, 16383));
        end
        push_item(kind, idx, amt);
      end
    end
    steady = 1'b0;
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("fit_policy_block_allocator_test OK");
    end else begin
      $display("fit_policy_block_allocator_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: fit_policy_block_allocator.f
rtl/core/fpba_pkg.sv
rtl/core/fpba_table.sv
rtl/core/fpba_ctrl.sv
rtl/core/fit_policy_block_allocator.sv
dv/fpba_grant_monitor.sv
dv/fit_policy_block_allocator_test.sv
